@@ rtl/core/advuuid_pkg.sv @@
// ----------------------------------------------------------------------------
// advuuid_pkg
// Shared types and constants of the 128-bit service UUID advertising filter.
// ----------------------------------------------------------------------------
`default_nettype none

package advuuid_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned UUID_W    = 128;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned PHASE_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_UUID_WORD0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UUID_WORD1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UUID_WORD2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UUID_WORD3 = 8'd3;

	localparam logic [WORD_W-1:0] UUID_WORD0_RST = 32'h11964EA2;
	localparam logic [WORD_W-1:0] UUID_WORD1_RST = 32'hBDCEEC4F;
	localparam logic [WORD_W-1:0] UUID_WORD2_RST = 32'h302D40C8;
	localparam logic [WORD_W-1:0] UUID_WORD3_RST = 32'hBB3343AC;

	localparam logic [BYTE_W-1:0] AD_TYPE_UUID128_PART = 8'h06;
	localparam logic [BYTE_W-1:0] AD_TYPE_UUID128_FULL = 8'h07;

	localparam logic [PHASE_W-1:0] PHASE_LEN  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_TYPE = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_BODY = 2'd2;

	typedef struct packed {
		logic valid;
		logic found;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/adv_uuid128_service_match.sv @@
// ----------------------------------------------------------------------------
// adv_uuid128_service_match
// Advertising payload filter that flags a configured 128-bit service UUID.
// ----------------------------------------------------------------------------
// The block takes one payload byte per beat, every cycle unless input stalls,
// and gives one service_found beat for each payload. A byte passes an input
// register and then the parser stage, which updates the field state; a verdict
// is held in the result register. Input only stalls when a last byte reaches
// the parser while the previous verdict still waits in the result register.
// The user must write configuration words while no payload is open; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module adv_uuid128_service_match
	import advuuid_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    payload_byte,
	input  wire logic                 last_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      service_found,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              step;
	logic [UUID_W-1:0] uuid;
	result_t           result;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= payload_byte;
			last_s1 <= last_byte;
		end
	end

	advuuid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.uuid      (uuid)
	);

	advuuid_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.uuid    (uuid),
		.result  (result)
	);

	advuuid_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.result        (result),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.service_found (service_found)
	);

`ifndef NO_ASSERTIONS
	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && last_s1))
		else $error("verdict appeared without a last byte in the parser stage");

	a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid && !out_ready))
		else $error("input stalled without a waiting verdict");

	a_no_verdict_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !result.valid)
		else $error("new verdict would overwrite one not yet taken");
`endif

endmodule

`default_nettype wire

@@ rtl/core/advuuid_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// advuuid_cfg_regs
// Holds the four configuration words that make up the target 128-bit UUID.
// ----------------------------------------------------------------------------
`default_nettype none

module advuuid_cfg_regs
	import advuuid_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	output logic [UUID_W-1:0]         uuid
);

	logic [WORD_W-1:0] word0_q;
	logic [WORD_W-1:0] word1_q;
	logic [WORD_W-1:0] word2_q;
	logic [WORD_W-1:0] word3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word0_q <= UUID_WORD0_RST;
			word1_q <= UUID_WORD1_RST;
			word2_q <= UUID_WORD2_RST;
			word3_q <= UUID_WORD3_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UUID_WORD0: word0_q <= cfg_data;
				REG_UUID_WORD1: word1_q <= cfg_data;
				REG_UUID_WORD2: word2_q <= cfg_data;
				REG_UUID_WORD3: word3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign uuid = {word3_q, word2_q, word1_q, word0_q};

endmodule

`default_nettype wire

@@ rtl/core/advuuid_parser.sv @@
// ----------------------------------------------------------------------------
// advuuid_parser
// Walks the length-type-value fields one byte per beat and compares the first
// sixteen body bytes of each 128-bit UUID list field with the target UUID.
// ----------------------------------------------------------------------------
`default_nettype none

module advuuid_parser
	import advuuid_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] byte_s1,
	input  wire logic              last_s1,
	input  wire logic [UUID_W-1:0] uuid,
	output result_t                result
);

	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  left_q;
	logic [IDX_W-1:0]   idx_q;
	logic               alive_q;
	logic               found_q;

	logic [PHASE_W-1:0] phase_d;
	logic [BYTE_W-1:0]  left_d;
	logic [IDX_W-1:0]   idx_d;
	logic               alive_d;
	logic               found_d;
	logic [BYTE_W-1:0]  left_dec;
	logic [BYTE_W-1:0]  uuid_byte;

	assign left_dec  = left_q - BYTE_W'(1);
	assign uuid_byte = uuid[{idx_q[IDX_W-2:0], 3'b000} +: BYTE_W];

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		idx_d   = idx_q;
		alive_d = alive_q;
		found_d = found_q;
		case (phase_q)
			PHASE_TYPE: begin
				left_d  = left_dec;
				alive_d = (byte_s1 == AD_TYPE_UUID128_PART) ||
					(byte_s1 == AD_TYPE_UUID128_FULL);
				idx_d   = '0;
				phase_d = (left_dec == '0) ? PHASE_LEN : PHASE_BODY;
			end
			PHASE_BODY: begin
				if (alive_q && !idx_q[IDX_W-1]) begin
					if (byte_s1 != uuid_byte) begin
						alive_d = 1'b0;
					end
					idx_d = idx_q + IDX_W'(1);
					if (idx_d[IDX_W-1] && alive_d) begin
						found_d = 1'b1;
					end
				end
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PHASE_LEN;
				end
			end
			default: begin
				if (byte_s1 != '0) begin
					left_d  = byte_s1;
					phase_d = PHASE_TYPE;
				end else begin
					phase_d = PHASE_LEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_LEN;
			left_q  <= '0;
			idx_q   <= '0;
			alive_q <= 1'b0;
			found_q <= 1'b0;
		end else if (step) begin
			if (last_s1) begin
				phase_q <= PHASE_LEN;
				left_q  <= '0;
				idx_q   <= '0;
				alive_q <= 1'b0;
				found_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
				idx_q   <= idx_d;
				alive_q <= alive_d;
				found_q <= found_d;
			end
		end
	end

	assign result.valid = step && last_s1;
	assign result.found = found_d;

endmodule

`default_nettype wire

@@ rtl/core/advuuid_out_reg.sv @@
// ----------------------------------------------------------------------------
// advuuid_out_reg
// Result register that holds one finished verdict until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module advuuid_out_reg
	import advuuid_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire result_t result,
	input  wire logic    out_ready,
	output logic         out_valid,
	output logic         service_found
);

	logic valid_q;
	logic found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			found_q <= result.found;
		end
	end

	assign out_valid     = valid_q;
	assign service_found = found_q;

endmodule

`default_nettype wire
